// ===== hw/rtl/mwf_pkg.sv =====
// Shared constants, types and command/status bundles for the maze wall follower.
`timescale 1ns / 1ps

package mwf_pkg;

    // Maze geometry
    localparam int MAZE_DIM = 8;
    localparam int COORD_W  = $clog2(MAZE_DIM);
    localparam int CELL_W   = 2 * COORD_W;

    // Path store sizing
    localparam int PATH_DEPTH  = 256;
    localparam int PATH_AW     = $clog2(PATH_DEPTH);
    localparam int LEN_W       = $clog2(PATH_DEPTH + 1);
    localparam int MAX_RESULTS = 64;
    localparam int CNT_W       = $clog2(MAX_RESULTS + 1);

    // Stream payload widths
    localparam int IN_DATA_W  = 16;
    localparam int OUT_DATA_W = 8;
    localparam int HEAD_W     = 2;

    // Input tdata bit offsets, lowest field first
    localparam int IN_CELL_X_LSB  = 0;
    localparam int IN_CELL_Y_LSB  = IN_CELL_X_LSB + COORD_W;
    localparam int IN_WALL_BIT    = IN_CELL_Y_LSB + COORD_W;
    localparam int IN_START_X_LSB = IN_WALL_BIT + 1;
    localparam int IN_START_Y_LSB = IN_START_X_LSB + COORD_W;
    localparam int IN_HEAD_LSB    = IN_START_Y_LSB + COORD_W;

    // Headings
    localparam logic [HEAD_W-1:0] HEAD_UP    = 2'd0;
    localparam logic [HEAD_W-1:0] HEAD_RIGHT = 2'd1;
    localparam logic [HEAD_W-1:0] HEAD_DOWN  = 2'd2;
    localparam logic [HEAD_W-1:0] HEAD_LEFT  = 2'd3;

    // Input item kinds carried on tuser
    localparam logic MODE_LOAD = 1'b0;
    localparam logic MODE_RUN  = 1'b1;

    typedef enum logic [1:0] {
        STATUS_OK       = 2'd0,
        STATUS_OVERFLOW = 2'd1,
        STATUS_ENCLOSED = 2'd2
    } status_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_RUN_FIRST,
        ST_RUN_REC,
        ST_PROBE,
        ST_SCAN_RD,
        ST_SCAN_LU,
        ST_SCAN_NX,
        ST_OUT_RD,
        ST_OUT_LU,
        ST_OUT_WR,
        ST_FAIL_OVF,
        ST_FAIL_ENC
    } state_t;

    // Controller to datapath commands
    typedef struct packed {
        logic    load_wall;
        logic    start_run;
        logic    record;
        logic    step;
        logic    turn_right;
        logic    turn_left;
        logic    erase_init;
        logic    rd_path;
        logic    rd_last;
        logic    advance;
        logic    out_load;
        logic    out_fail;
        status_t out_status;
    } cmd_t;

    // Datapath to controller status
    typedef struct packed {
        logic full;
        logic interior;
        logic blocked;
        logic tries_max;
        logic scan_done;
        logic cnt_max;
        logic out_free;
        logic last_cell;
    } stat_t;

endpackage

// ===== hw/rtl/maze_wall_follower_loop_erase.sv =====
// Top level: right-hand wall follower with loop erasure on stream interfaces.
// Loads are accepted back to back while idle. A run records the start cell and steps,
// then per walk step records a cell and makes one to four wall probes (one wall probe
// per cycle); it then counts the surviving cells (read, look up, advance per cell) and
// emits them (read, look up, write per cell), stalled by output back-pressure; one run is in flight at a time.
// Reset (async, active low) clears the wall store, controller and output valid.
`timescale 1ns / 1ps

module maze_wall_follower_loop_erase (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           s_axis_tvalid,
    output logic                           s_axis_tready,
    // cell_x[2:0], cell_y[5:3], cell_wall[6], start_x[9:7], start_y[12:10],
    // start_heading[14:13], zero fill[15]
    input  logic [mwf_pkg::IN_DATA_W-1:0]  s_axis_tdata,
    // mode[0]
    input  logic                           s_axis_tuser,
    output logic                           m_axis_tvalid,
    input  logic                           m_axis_tready,
    // path_x[2:0], path_y[5:3], zero fill[7:6]
    output logic [mwf_pkg::OUT_DATA_W-1:0] m_axis_tdata,
    output logic                           m_axis_tlast,
    // status[1:0]
    output logic [1:0]                     m_axis_tuser
);

    mwf_pkg::cmd_t  cmd;
    mwf_pkg::stat_t stat;

    // Sequencer
    mwf_ctrl u_ctrl (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .mode          (s_axis_tuser),
        .stat          (stat),
        .cmd           (cmd)
    );

    // Storage and arithmetic
    mwf_dp u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tdata  (s_axis_tdata),
        .cmd           (cmd),
        .stat          (stat),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .m_axis_tuser  (m_axis_tuser)
    );

endmodule

// ===== hw/rtl/mwf_ctrl.sv =====
// Sequencing state machine for loading, walking, loop erasure and emission.
`timescale 1ns / 1ps

module mwf_ctrl (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           s_axis_tvalid,
    output logic           s_axis_tready,
    input  logic           mode,
    input  mwf_pkg::stat_t stat,
    output mwf_pkg::cmd_t  cmd
);

    mwf_pkg::state_t state_reg;
    mwf_pkg::state_t state_next;

    // State register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= mwf_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            mwf_pkg::ST_IDLE:
            begin
                if (s_axis_tvalid && (mode == mwf_pkg::MODE_RUN))
                begin
                    state_next = mwf_pkg::ST_RUN_FIRST;
                end
            end
            mwf_pkg::ST_RUN_FIRST:
            begin
                state_next = mwf_pkg::ST_RUN_REC;
            end
            mwf_pkg::ST_RUN_REC:
            begin
                priority if (stat.full)
                begin
                    state_next = mwf_pkg::ST_FAIL_OVF;
                end
                else if (stat.interior)
                begin
                    state_next = mwf_pkg::ST_PROBE;
                end
                else
                begin
                    state_next = mwf_pkg::ST_SCAN_RD;
                end
            end
            mwf_pkg::ST_PROBE:
            begin
                priority if (!stat.blocked)
                begin
                    state_next = mwf_pkg::ST_RUN_REC;
                end
                else if (stat.tries_max)
                begin
                    state_next = mwf_pkg::ST_FAIL_ENC;
                end
                else
                begin
                    state_next = mwf_pkg::ST_PROBE;
                end
            end
            mwf_pkg::ST_SCAN_RD:
            begin
                state_next = stat.scan_done ? mwf_pkg::ST_OUT_RD : mwf_pkg::ST_SCAN_LU;
            end
            mwf_pkg::ST_SCAN_LU:
            begin
                state_next = mwf_pkg::ST_SCAN_NX;
            end
            mwf_pkg::ST_SCAN_NX:
            begin
                state_next = stat.cnt_max ? mwf_pkg::ST_FAIL_OVF : mwf_pkg::ST_SCAN_RD;
            end
            mwf_pkg::ST_OUT_RD:
            begin
                state_next = mwf_pkg::ST_OUT_LU;
            end
            mwf_pkg::ST_OUT_LU:
            begin
                state_next = mwf_pkg::ST_OUT_WR;
            end
            mwf_pkg::ST_OUT_WR:
            begin
                if (stat.out_free)
                begin
                    state_next = stat.last_cell ? mwf_pkg::ST_IDLE : mwf_pkg::ST_OUT_RD;
                end
            end
            mwf_pkg::ST_FAIL_OVF,
            mwf_pkg::ST_FAIL_ENC:
            begin
                if (stat.out_free)
                begin
                    state_next = mwf_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = mwf_pkg::ST_IDLE;
            end
        endcase
    end

    // Commands to the datapath
    always_comb
    begin
        cmd            = '0;
        cmd.out_status = mwf_pkg::STATUS_OK;
        s_axis_tready  = 1'b0;
        unique case (state_reg)
            mwf_pkg::ST_IDLE:
            begin
                s_axis_tready = 1'b1;
                cmd.load_wall = s_axis_tvalid && (mode == mwf_pkg::MODE_LOAD);
                cmd.start_run = s_axis_tvalid && (mode == mwf_pkg::MODE_RUN);
            end
            mwf_pkg::ST_RUN_FIRST:
            begin
                cmd.record = 1'b1;
                cmd.step   = 1'b1;
            end
            mwf_pkg::ST_RUN_REC:
            begin
                cmd.record     = !stat.full;
                cmd.turn_right = !stat.full && stat.interior;
                cmd.erase_init = !stat.full && !stat.interior;
            end
            mwf_pkg::ST_PROBE:
            begin
                cmd.step      = !stat.blocked;
                cmd.turn_left = stat.blocked && !stat.tries_max;
            end
            mwf_pkg::ST_SCAN_RD:
            begin
                cmd.rd_path    = !stat.scan_done;
                cmd.erase_init = stat.scan_done;
            end
            mwf_pkg::ST_SCAN_LU,
            mwf_pkg::ST_OUT_LU:
            begin
                cmd.rd_last = 1'b1;
            end
            mwf_pkg::ST_SCAN_NX:
            begin
                cmd.advance = !stat.cnt_max;
            end
            mwf_pkg::ST_OUT_RD:
            begin
                cmd.rd_path = 1'b1;
            end
            mwf_pkg::ST_OUT_WR:
            begin
                cmd.out_load = stat.out_free;
                cmd.advance  = stat.out_free;
            end
            mwf_pkg::ST_FAIL_OVF:
            begin
                cmd.out_load   = stat.out_free;
                cmd.out_fail   = 1'b1;
                cmd.out_status = mwf_pkg::STATUS_OVERFLOW;
            end
            mwf_pkg::ST_FAIL_ENC:
            begin
                cmd.out_load   = stat.out_free;
                cmd.out_fail   = 1'b1;
                cmd.out_status = mwf_pkg::STATUS_ENCLOSED;
            end
            default:
            begin
                cmd = '0;
            end
        endcase
    end

    // A probe only ever happens from an interior cell
    a_probe_interior: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == mwf_pkg::ST_PROBE) |-> stat.interior)
        else $error("probe issued outside the interior");

    // Input is taken only while idle
    a_ready_idle: assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tready |-> (state_reg == mwf_pkg::ST_IDLE))
        else $error("input ready outside idle");

    // Never turn both ways in one cycle
    a_one_turn: assert property (@(posedge clk) disable iff (!rst_n)
        !(cmd.turn_right && cmd.turn_left))
        else $error("right and left turn together");

endmodule

// ===== hw/rtl/mwf_dp.sv =====
// Datapath: wall store, walker, path store, last-visit table and output register.
`timescale 1ns / 1ps

module mwf_dp (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic [mwf_pkg::IN_DATA_W-1:0]    s_axis_tdata,
    input  mwf_pkg::cmd_t                    cmd,
    output mwf_pkg::stat_t                   stat,
    output logic                             m_axis_tvalid,
    input  logic                             m_axis_tready,
    output logic [mwf_pkg::OUT_DATA_W-1:0]   m_axis_tdata,
    output logic                             m_axis_tlast,
    output logic [1:0]                       m_axis_tuser
);

    localparam int CW = mwf_pkg::COORD_W;
    localparam int HW = mwf_pkg::HEAD_W;
    localparam int EW = mwf_pkg::CELL_W;
    localparam int AW = mwf_pkg::PATH_AW;
    localparam int LW = mwf_pkg::LEN_W;
    localparam int NW = mwf_pkg::CNT_W;
    localparam logic [CW-1:0] COORD_MAX = CW'(mwf_pkg::MAZE_DIM - 1);

    // Input field slices
    logic [CW-1:0] in_cell_x;
    logic [CW-1:0] in_cell_y;
    logic          in_cell_wall;
    logic [CW-1:0] in_start_x;
    logic [CW-1:0] in_start_y;
    logic [HW-1:0] in_heading;

    assign in_cell_x    = s_axis_tdata[mwf_pkg::IN_CELL_X_LSB +: CW];
    assign in_cell_y    = s_axis_tdata[mwf_pkg::IN_CELL_Y_LSB +: CW];
    assign in_cell_wall = s_axis_tdata[mwf_pkg::IN_WALL_BIT];
    assign in_start_x   = s_axis_tdata[mwf_pkg::IN_START_X_LSB +: CW];
    assign in_start_y   = s_axis_tdata[mwf_pkg::IN_START_Y_LSB +: CW];
    assign in_heading   = s_axis_tdata[mwf_pkg::IN_HEAD_LSB +: HW];

    // One step along a heading, wrapping at the grid edge
    function automatic logic [CW-1:0] step_x(input logic [CW-1:0] x, input logic [HW-1:0] h);
        logic [CW-1:0] r;
        r = x;
        if (h == mwf_pkg::HEAD_RIGHT)
        begin
            r = (x == COORD_MAX) ? '0 : x + CW'(1);
        end
        else if (h == mwf_pkg::HEAD_LEFT)
        begin
            r = (x == '0) ? COORD_MAX : x - CW'(1);
        end
        return r;
    endfunction

    function automatic logic [CW-1:0] step_y(input logic [CW-1:0] y, input logic [HW-1:0] h);
        logic [CW-1:0] r;
        r = y;
        if (h == mwf_pkg::HEAD_DOWN)
        begin
            r = (y == COORD_MAX) ? '0 : y + CW'(1);
        end
        else if (h == mwf_pkg::HEAD_UP)
        begin
            r = (y == '0) ? COORD_MAX : y - CW'(1);
        end
        return r;
    endfunction

    logic [mwf_pkg::MAZE_DIM-1:0] walls_reg [mwf_pkg::MAZE_DIM];
    logic [CW-1:0]                walker_x_reg;
    logic [CW-1:0]                walker_y_reg;
    logic [HW-1:0]                heading_reg;
    logic [1:0]                   tries_reg;
    logic [LW-1:0]                len_reg;
    logic [LW-1:0]                p_reg;
    logic [NW-1:0]                cnt_reg;
    logic [EW-1:0]                path_mem [mwf_pkg::PATH_DEPTH];
    logic [AW-1:0]                last_mem [2**EW];
    logic [EW-1:0]                path_rdata_reg;
    logic [AW-1:0]                last_rdata_reg;
    logic                         out_valid_reg;
    logic [CW-1:0]                out_x_reg;
    logic [CW-1:0]                out_y_reg;
    logic                         out_last_reg;
    mwf_pkg::status_t             out_status_reg;

    logic [CW-1:0] probe_x;
    logic [CW-1:0] probe_y;
    logic [EW-1:0] cur_cell;
    logic [LW-1:0] p_next;
    logic          out_free;

    assign probe_x  = step_x(walker_x_reg, heading_reg);
    assign probe_y  = step_y(walker_y_reg, heading_reg);
    assign cur_cell = {walker_y_reg, walker_x_reg};
    assign p_next   = LW'(last_rdata_reg) + LW'(1);
    assign out_free = !out_valid_reg || m_axis_tready;

    // Status to the controller
    always_comb
    begin
        stat.full      = (len_reg == LW'(mwf_pkg::PATH_DEPTH));
        stat.interior  = (walker_x_reg != '0) && (walker_x_reg != COORD_MAX) &&
                         (walker_y_reg != '0) && (walker_y_reg != COORD_MAX);
        stat.blocked   = walls_reg[probe_y][probe_x];
        stat.tries_max = (tries_reg == 2'd3);
        stat.scan_done = (p_reg == len_reg);
        stat.cnt_max   = (cnt_reg == NW'(mwf_pkg::MAX_RESULTS));
        stat.out_free  = out_free;
        stat.last_cell = (p_next == len_reg);
    end

    // Wall store: one row of flops per maze row, cleared at reset
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < mwf_pkg::MAZE_DIM; i++)
            begin
                walls_reg[i] <= '0;
            end
        end
        else if (cmd.load_wall)
        begin
            walls_reg[in_cell_y][in_cell_x] <= in_cell_wall;
        end
    end

    // Walker position and heading
    always_ff @(posedge clk)
    begin
        if (cmd.start_run)
        begin
            walker_x_reg <= in_start_x;
            walker_y_reg <= in_start_y;
            heading_reg  <= in_heading;
        end
        else
        begin
            if (cmd.step)
            begin
                walker_x_reg <= probe_x;
                walker_y_reg <= probe_y;
            end
            if (cmd.turn_right)
            begin
                heading_reg <= heading_reg + HW'(1);
            end
            else if (cmd.turn_left)
            begin
                heading_reg <= heading_reg - HW'(1);
            end
        end
        if (cmd.turn_right)
        begin
            tries_reg <= '0;
        end
        else if (cmd.turn_left)
        begin
            tries_reg <= tries_reg + 2'd1;
        end
    end

    // Path length, erase pointer and survivor count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            len_reg <= '0;
            p_reg   <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            if (cmd.start_run)
            begin
                len_reg <= '0;
            end
            else if (cmd.record)
            begin
                len_reg <= len_reg + LW'(1);
            end
            if (cmd.start_run || cmd.erase_init)
            begin
                p_reg   <= '0;
                cnt_reg <= '0;
            end
            else if (cmd.advance)
            begin
                p_reg   <= p_next;
                cnt_reg <= cnt_reg + NW'(1);
            end
        end
    end

    // Path store
    always_ff @(posedge clk)
    begin
        if (cmd.record)
        begin
            path_mem[len_reg[AW-1:0]] <= cur_cell;
        end
        if (cmd.rd_path)
        begin
            path_rdata_reg <= path_mem[p_reg[AW-1:0]];
        end
    end

    // Last-visit table: latest path index of each cell in this run
    always_ff @(posedge clk)
    begin
        if (cmd.record)
        begin
            last_mem[cur_cell] <= len_reg[AW-1:0];
        end
        if (cmd.rd_last)
        begin
            last_rdata_reg <= last_mem[path_rdata_reg];
        end
    end

    // Output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.out_load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_axis_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.out_load)
        begin
            out_status_reg <= cmd.out_status;
            if (cmd.out_fail)
            begin
                out_x_reg    <= '0;
                out_y_reg    <= '0;
                out_last_reg <= 1'b1;
            end
            else
            begin
                out_x_reg    <= path_rdata_reg[CW-1:0];
                out_y_reg    <= path_rdata_reg[EW-1:CW];
                out_last_reg <= stat.last_cell;
            end
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {{(mwf_pkg::OUT_DATA_W - EW){1'b0}}, out_y_reg, out_x_reg};
    assign m_axis_tlast  = out_last_reg;
    assign m_axis_tuser  = out_status_reg;

    a_rec_room: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.record |-> !stat.full)
        else $error("record into a full path store");

    a_out_room: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.out_load |-> out_free)
        else $error("output register overwritten before it was taken");

    a_ptr_bound: assert property (@(posedge clk) disable iff (!rst_n)
        p_reg <= len_reg)
        else $error("erase pointer beyond path length");

    a_len_bound: assert property (@(posedge clk) disable iff (!rst_n)
        len_reg <= LW'(mwf_pkg::PATH_DEPTH))
        else $error("path length beyond store depth");

endmodule
